[rtl/pbe_pkg.sv]
package pbe_pkg;

  localparam int unsigned POSITION_WIDTH = 20;

  localparam logic [63:0] COLOR_RESET = 64'h8080_8080_8080_8080;
  localparam logic [2:0]  LAST_CORNER = 3'd5;

  typedef enum logic [2:0] {
    CFG_START_COLORS   = 3'd0,
    CFG_MID_COLORS     = 3'd1,
    CFG_END_COLORS     = 3'd2,
    CFG_MID_POINT      = 3'd3,
    CFG_SCREEN_RIGHT   = 3'd4,
    CFG_SCREEN_UP      = 3'd5,
    CFG_EMITTER_ORIGIN = 3'd6,
    CFG_TEXTURED       = 3'd7
  } cfg_idx_e;

  typedef enum logic [1:0] {
    SGN_ZERO,
    SGN_POS,
    SGN_NEG
  } sgn_e;

  typedef struct packed {
    logic [15:0] age;
    logic [15:0] lifetime;
    logic [15:0] start_half_width;
    logic [15:0] end_half_width;
    logic [15:0] start_half_height;
    logic [15:0] end_half_height;
    logic signed [19:0] pos_x;
    logic signed [19:0] pos_y;
    logic signed [19:0] pos_z;
  } particle_t;

  typedef struct packed {
    logic signed [POSITION_WIDTH-1:0] vert_x;
    logic signed [POSITION_WIDTH-1:0] vert_y;
    logic signed [POSITION_WIDTH-1:0] vert_z;
    logic [31:0] vert_color;
    logic [1:0]  tex_u;
    logic [1:0]  tex_v;
    logic [2:0]  fan_index;
    logic        last_vertex;
  } vertex_t;

  // fan corner signs: -+, ++, +-, --, -+
  function automatic sgn_e corner_right(input logic [2:0] k);
    sgn_e s;
    case (k)
      3'd0:           s = SGN_ZERO;
      3'd2, 3'd3:     s = SGN_POS;
      default:        s = SGN_NEG;
    endcase
    return s;
  endfunction

  function automatic sgn_e corner_up(input logic [2:0] k);
    sgn_e s;
    case (k)
      3'd0:           s = SGN_ZERO;
      3'd3, 3'd4:     s = SGN_NEG;
      default:        s = SGN_POS;
    endcase
    return s;
  endfunction

  function automatic logic [1:0] corner_u(input logic [2:0] k);
    logic [1:0] u;
    case (k)
      3'd0:       u = 2'd1;
      3'd2, 3'd3: u = 2'd2;
      default:    u = 2'd0;
    endcase
    return u;
  endfunction

  function automatic logic [1:0] corner_v(input logic [2:0] k);
    logic [1:0] v;
    case (k)
      3'd0:       v = 2'd1;
      3'd3, 3'd4: v = 2'd2;
      default:    v = 2'd0;
    endcase
    return v;
  endfunction

endpackage

[rtl/particle_billboard_expander.sv]
// channel   direction  handshake                 payload
// in        input      in_valid_i / in_stall_o   in_data_i  (particle_t)
// out       output     out_valid_o / out_stall_i out_data_o (vertex_t)
// cfg       input      cfg_we_i                  cfg_idx_i, cfg_data_i
//
// One particle per fan of six vertices: the fan expander emits one vertex a cycle
// while out_stall_i is low. Pipeline: two restoring dividers, one quotient bit per
// stage, then lerp and multiply stages. in_stall_o rises while a fan is pending.
// Reset clears valid bits and loads the register reset values.
// Out stall freezes the pipe only while the fan expander holds a particle.
module particle_billboard_expander import pbe_pkg::*; #(
  parameter int unsigned FRACTION_BITS = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  particle_t   in_data_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output vertex_t     out_data_o,
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_idx_i,
  input  logic [63:0] cfg_data_i
);

  localparam int unsigned FB = FRACTION_BITS;
  localparam int unsigned TW = FB + 1;
  localparam int unsigned PW = FB + 19;
  localparam int unsigned CW = FB + 11;
  localparam int unsigned VW = 23;
  localparam logic [TW-1:0] ONE = {1'b1, {FB{1'b0}}};
  localparam logic signed [VW-1:0] VMAX = VW'((64'sd1 <<< (POSITION_WIDTH - 1)) - 1);
  localparam logic signed [VW-1:0] VMIN = -VMAX - VW'(1);

  // ---------------- configuration
  logic [63:0] start_q, mid_q, end_q;
  logic [16:0] midpt_q;
  logic [47:0] right_q, up_q;
  logic [59:0] origin_q;
  logic        tex_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_q  <= COLOR_RESET;
      mid_q    <= COLOR_RESET;
      end_q    <= COLOR_RESET;
      midpt_q  <= '0;
      right_q  <= '0;
      up_q     <= '0;
      origin_q <= '0;
      tex_q    <= 1'b0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_idx_i))
        CFG_START_COLORS:   start_q  <= cfg_data_i;
        CFG_MID_COLORS:     mid_q    <= cfg_data_i;
        CFG_END_COLORS:     end_q    <= cfg_data_i;
        CFG_MID_POINT:      midpt_q  <= cfg_data_i[16:0];
        CFG_SCREEN_RIGHT:   right_q  <= cfg_data_i[47:0];
        CFG_SCREEN_UP:      up_q     <= cfg_data_i[47:0];
        CFG_EMITTER_ORIGIN: origin_q <= cfg_data_i[59:0];
        CFG_TEXTURED:       tex_q    <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  // ---------------- pipeline control
  logic       adv, out_load;
  logic       ex_valid_q, out_valid_q;
  logic [2:0] k_q;
  vertex_t    out_q;

  assign out_load   = !out_valid_q || !out_stall_i;
  assign adv        = !ex_valid_q || (out_load && (k_q == LAST_CORNER));
  assign in_stall_o = !adv;

  // ---------------- age fraction divider
  typedef struct packed {
    logic [15:0] life;
    logic [15:0] sw, ew, sh, eh;
    logic [2:0][20:0] ctr;
    logic        full;
    logic [15:0] rem;
    logic [FB-1:0] q;
  } d1_t;

  logic d1_v_q [0:FB];
  d1_t  d1_q   [0:FB];
  d1_t  d1_in;

  always_comb begin
    d1_in.life   = in_data_i.lifetime;
    d1_in.sw     = in_data_i.start_half_width;
    d1_in.ew     = in_data_i.end_half_width;
    d1_in.sh     = in_data_i.start_half_height;
    d1_in.eh     = in_data_i.end_half_height;
    d1_in.ctr[0] = {in_data_i.pos_x[19], in_data_i.pos_x} + {origin_q[59], origin_q[59:40]};
    d1_in.ctr[1] = {in_data_i.pos_y[19], in_data_i.pos_y} + {origin_q[39], origin_q[39:20]};
    d1_in.ctr[2] = {in_data_i.pos_z[19], in_data_i.pos_z} + {origin_q[19], origin_q[19:0]};
    d1_in.full   = (in_data_i.lifetime == '0) || (in_data_i.age >= in_data_i.lifetime);
    d1_in.rem    = in_data_i.age;
    d1_in.q      = '0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      d1_v_q[0] <= 1'b0;
    end else if (adv) begin
      d1_v_q[0] <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      d1_q[0] <= d1_in;
    end
  end

  for (genvar j = 0; j < FB; j++) begin : g_div1
    logic [16:0] r2;
    logic        ge;
    d1_t         nx;
    always_comb begin
      r2     = {d1_q[j].rem, 1'b0};
      ge     = r2 >= {1'b0, d1_q[j].life};
      nx     = d1_q[j];
      nx.rem = ge ? 16'(r2 - {1'b0, d1_q[j].life}) : r2[15:0];
      nx.q   = {d1_q[j].q[FB-2:0], ge};
    end
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        d1_v_q[j+1] <= 1'b0;
      end else if (adv) begin
        d1_v_q[j+1] <= d1_v_q[j];
      end
    end
    always_ff @(posedge clk_i) begin
      if (adv) begin
        d1_q[j+1] <= nx;
      end
    end
  end

  // ---------------- color fraction divider
  typedef struct packed {
    logic [TW-1:0] t;
    logic          mid, hi, eq;
    logic [TW-1:0] d, rem;
    logic [FB-1:0] q;
    logic [PW-1:0] pw, ph;
    logic [15:0]   sw, sh;
    logic [2:0][20:0] ctr;
  } d2_t;

  logic d2_v_q [0:FB];
  d2_t  d2_q   [0:FB];
  d2_t  d2_in;

  logic [TW-1:0] t0, n0, m0;
  logic [FB+15:0] mw;

  always_comb begin
    t0 = d1_q[FB].full ? ONE : {1'b0, d1_q[FB].q};
    mw = {midpt_q[15:0], {FB{1'b0}}};
    m0 = {1'b0, mw[FB+15:16]};
    d2_in.t   = t0;
    d2_in.mid = midpt_q[16];
    d2_in.hi  = t0 >= m0;
    if (!midpt_q[16]) begin
      n0      = '0;
      d2_in.d = TW'(1);
    end else if (t0 < m0) begin
      n0      = t0;
      d2_in.d = m0;
    end else begin
      n0      = t0 - m0;
      d2_in.d = ONE - m0;
    end
    d2_in.eq  = n0 == d2_in.d;
    d2_in.rem = n0;
    d2_in.q   = '0;
    d2_in.pw  = PW'(($signed({1'b0, d1_q[FB].ew}) - $signed({1'b0, d1_q[FB].sw}))
                    * $signed({1'b0, t0}));
    d2_in.ph  = PW'(($signed({1'b0, d1_q[FB].eh}) - $signed({1'b0, d1_q[FB].sh}))
                    * $signed({1'b0, t0}));
    d2_in.sw  = d1_q[FB].sw;
    d2_in.sh  = d1_q[FB].sh;
    d2_in.ctr = d1_q[FB].ctr;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      d2_v_q[0] <= 1'b0;
    end else if (adv) begin
      d2_v_q[0] <= d1_v_q[FB];
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      d2_q[0] <= d2_in;
    end
  end

  for (genvar j = 0; j < FB; j++) begin : g_div2
    logic [TW:0] r2;
    logic        ge;
    d2_t         nx;
    always_comb begin
      r2     = {d2_q[j].rem, 1'b0};
      ge     = r2 >= {1'b0, d2_q[j].d};
      nx     = d2_q[j];
      nx.rem = ge ? TW'(r2 - {1'b0, d2_q[j].d}) : r2[TW-1:0];
      nx.q   = {d2_q[j].q[FB-2:0], ge};
    end
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        d2_v_q[j+1] <= 1'b0;
      end else if (adv) begin
        d2_v_q[j+1] <= d2_v_q[j];
      end
    end
    always_ff @(posedge clk_i) begin
      if (adv) begin
        d2_q[j+1] <= nx;
      end
    end
  end

  // ---------------- E1: sizes and color products
  typedef struct packed {
    logic [15:0] w, h;
    logic [2:0][20:0] ctr;
    logic [7:0][7:0] ca;
    logic [7:0][CW-1:0] cp;
  } e1_t;

  logic e1_v_q;
  e1_t  e1_q, e1_d;

  logic [TW-1:0] ct;
  logic [63:0]   ca_w, cb_w;
  logic signed [PW-1:0] pws, phs;
  logic signed [18:0] dw, dh;
  logic signed [18:0] ws, hs;

  always_comb begin
    ct  = !d2_q[FB].mid ? d2_q[FB].t : (d2_q[FB].eq ? ONE : {1'b0, d2_q[FB].q});
    pws = $signed(d2_q[FB].pw);
    phs = $signed(d2_q[FB].ph);
    // divide by 2^FB, rounding toward zero
    dw  = 19'(pws >>> FB) + 19'(pws[PW-1] && (|pws[FB-1:0]));
    dh  = 19'(phs >>> FB) + 19'(phs[PW-1] && (|phs[FB-1:0]));
    ws  = $signed({3'b000, d2_q[FB].sw}) + dw;
    hs  = $signed({3'b000, d2_q[FB].sh}) + dh;
    if (!d2_q[FB].mid) begin
      ca_w = start_q;
      cb_w = end_q;
    end else if (!d2_q[FB].hi) begin
      ca_w = start_q;
      cb_w = mid_q;
    end else begin
      ca_w = mid_q;
      cb_w = end_q;
    end
    e1_d.w   = ws[15:0];
    e1_d.h   = hs[15:0];
    e1_d.ctr = d2_q[FB].ctr;
    for (int c = 0; c < 8; c++) begin
      e1_d.ca[c] = ca_w[8*c +: 8];
      e1_d.cp[c] = CW'(($signed({1'b0, cb_w[8*c +: 8]}) - $signed({1'b0, ca_w[8*c +: 8]}))
                       * $signed({1'b0, ct}));
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      e1_v_q <= 1'b0;
    end else if (adv) begin
      e1_v_q <= d2_v_q[FB];
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      e1_q <= e1_d;
    end
  end

  // ---------------- E2: offset products and final colors
  typedef struct packed {
    logic [2:0][32:0] rp, up;
    logic [63:0] col;
    logic [2:0][20:0] ctr;
  } e2_t;

  logic e2_v_q;
  e2_t  e2_q, e2_d;

  always_comb begin
    e2_d.ctr = e1_q.ctr;
    for (int c = 0; c < 8; c++) begin
      logic signed [CW-1:0] p;
      logic signed [8:0]    dl;
      p  = $signed(e1_q.cp[c]);
      dl = 9'(p >>> FB) + 9'(p[CW-1] && (|p[FB-1:0]));
      e2_d.col[8*c +: 8] = 8'($signed({1'b0, e1_q.ca[c]}) + dl);
    end
    for (int i = 0; i < 3; i++) begin
      e2_d.rp[i] = 33'($signed(right_q[32-16*i +: 16]) * $signed({1'b0, e1_q.w}));
      e2_d.up[i] = 33'($signed(up_q[32-16*i +: 16]) * $signed({1'b0, e1_q.h}));
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      e2_v_q <= 1'b0;
    end else if (adv) begin
      e2_v_q <= e1_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      e2_q <= e2_d;
    end
  end

  // ---------------- fan expander
  logic [2:0][18:0] rv_q, uv_q, rv_d, uv_d;
  logic [2:0][20:0] ctr_q;
  logic [31:0]      c0_q, c1_q;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      logic signed [32:0] a, b;
      a = $signed(e2_q.rp[i]);
      b = $signed(e2_q.up[i]);
      rv_d[i] = 19'(a >>> 14) + 19'(a[32] && (|a[13:0]));
      uv_d[i] = 19'(b >>> 14) + 19'(b[32] && (|b[13:0]));
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ex_valid_q <= 1'b0;
      k_q        <= '0;
    end else if (adv) begin
      ex_valid_q <= e2_v_q;
      k_q        <= '0;
    end else if (out_load && ex_valid_q) begin
      k_q <= k_q + 3'd1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      rv_q  <= rv_d;
      uv_q  <= uv_d;
      ctr_q <= e2_q.ctr;
      c0_q  <= e2_q.col[63:32];
      c1_q  <= e2_q.col[31:0];
    end
  end

  vertex_t vtx;
  logic signed [2:0][VW-1:0] vsum;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      // element selects of a packed array are unsigned, so work in a signed local
      logic signed [VW-1:0] rt, ut, s;
      rt = VW'($signed(rv_q[i]));
      ut = VW'($signed(uv_q[i]));
      s  = VW'($signed(ctr_q[i]));
      case (corner_right(k_q))
        SGN_POS: s = s + rt;
        SGN_NEG: s = s - rt;
        default: ;
      endcase
      case (corner_up(k_q))
        SGN_POS: s = s + ut;
        SGN_NEG: s = s - ut;
        default: ;
      endcase
      if (s > VMAX) begin
        s = VMAX;
      end else if (s < VMIN) begin
        s = VMIN;
      end
      vsum[i] = s;
    end
    vtx.vert_x      = vsum[0][POSITION_WIDTH-1:0];
    vtx.vert_y      = vsum[1][POSITION_WIDTH-1:0];
    vtx.vert_z      = vsum[2][POSITION_WIDTH-1:0];
    vtx.vert_color  = (k_q == '0) ? c0_q : c1_q;
    vtx.tex_u       = tex_q ? corner_u(k_q) : 2'd0;
    vtx.tex_v       = tex_q ? corner_v(k_q) : 2'd0;
    vtx.fan_index   = k_q;
    vtx.last_vertex = k_q == LAST_CORNER;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= ex_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load && ex_valid_q) begin
      out_q <= vtx;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

`ifndef SYNTHESIS
  a_hold_while_fan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ex_valid_q && (k_q != LAST_CORNER)) |-> in_stall_o)
    else $error("input taken while a fan is still pending");

  a_last_is_five: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (out_data_o.last_vertex == (out_data_o.fan_index == LAST_CORNER)))
    else $error("last_vertex does not match fan index");

  a_fan_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_stall_i && ex_valid_q && (out_data_o.fan_index != LAST_CORNER))
    |=> (out_valid_o && (out_data_o.fan_index == $past(out_data_o.fan_index) + 3'd1)))
    else $error("fan vertices out of order");
`endif

endmodule

[dv/testbench.sv]
`timescale 1ns / 100ps

module testbench;
  import pbe_pkg::*;

  localparam int unsigned FRAC = 16;
  localparam longint ONE = 64'd1 << FRAC;
  localparam int unsigned PIPE_LAT = 2 * FRAC + 5;
  localparam int unsigned STALL_LIMIT = 20000;
  localparam int unsigned N_RANDOM = 390;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_stall;
  particle_t   in_data;
  logic        out_valid;
  logic        out_stall;
  vertex_t     out_data;
  logic        cfg_we;
  logic [2:0]  cfg_idx;
  logic [63:0] cfg_data;

  particle_billboard_expander #(.FRACTION_BITS(FRAC)) dut (
    .clk_i(clk), .rst_ni(rst_n),
    .in_valid_i(in_valid), .in_stall_o(in_stall), .in_data_i(in_data),
    .out_valid_o(out_valid), .out_stall_i(out_stall), .out_data_o(out_data),
    .cfg_we_i(cfg_we), .cfg_idx_i(cfg_idx), .cfg_data_i(cfg_data)
  );

  // shadow copy of the block's registers
  logic [63:0] sh_start, sh_mid, sh_end;
  logic [16:0] sh_midpt;
  logic [47:0] sh_right, sh_up;
  logic [59:0] sh_origin;
  logic        sh_tex;

  particle_t particle_q[$];
  vertex_t   vertex_q[$];
  int        errors;
  int        n_accepted;
  int        n_vertices;
  int        idle_cnt;
  bit        hold_out;
  int        hold_len;
  int        in_gap;
  int        out_gap;
  logic      in_taken;

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  function automatic longint lerp_val(longint a, longint b, longint t);
    return a + ((b - a) * t) / ONE;
  endfunction

  function automatic logic [31:0] blend_color(logic [31:0] a, logic [31:0] b, longint t);
    logic [31:0] r;
    longint c;
    for (int sh = 0; sh < 32; sh += 8) begin
      c = lerp_val(longint'(a[sh +: 8]), longint'(b[sh +: 8]), t);
      r[sh +: 8] = c[7:0];
    end
    return r;
  endfunction

  function automatic longint clamp_pos(longint v);
    if (v > 524287) return 524287;
    if (v < -524288) return -524288;
    return v;
  endfunction

  task automatic build_fan(input particle_t p);
    longint t, ct, m, w, h, v;
    longint ctr[3], rv[3], uv[3];
    logic [63:0] regs[3];
    logic [31:0] c0, c1;
    int sa, ea, sr, su;
    vertex_t vx;
    if (p.lifetime == 0 || p.age >= p.lifetime) t = ONE;
    else t = (longint'(p.age) * ONE) / longint'(p.lifetime);
    w = lerp_val(p.start_half_width, p.end_half_width, t);
    h = lerp_val(p.start_half_height, p.end_half_height, t);
    ctr[0] = longint'(p.pos_x) + longint'($signed(sh_origin[59:40]));
    ctr[1] = longint'(p.pos_y) + longint'($signed(sh_origin[39:20]));
    ctr[2] = longint'(p.pos_z) + longint'($signed(sh_origin[19:0]));
    for (int i = 0; i < 3; i++) begin
      rv[i] = (longint'($signed(sh_right[32 - 16 * i +: 16])) * w) / 16384;
      uv[i] = (longint'($signed(sh_up[32 - 16 * i +: 16])) * h) / 16384;
    end
    m = (longint'(sh_midpt[15:0]) << FRAC) >> 16;
    ct = t;
    sa = 0;
    ea = 2;
    if (sh_midpt[16]) begin
      if (t < m) begin
        ea = 1;
        ct = (t * ONE) / m;
      end else begin
        sa = 1;
        ct = ((t - m) * ONE) / (ONE - m);
      end
    end
    regs[0] = sh_start;
    regs[1] = sh_mid;
    regs[2] = sh_end;
    c0 = blend_color(regs[sa][63:32], regs[ea][63:32], ct);
    c1 = blend_color(regs[sa][31:0], regs[ea][31:0], ct);
    for (int k = 0; k < 6; k++) begin
      case (k)
        0: begin sr = 0; su = 0; vx.tex_u = 2'd1; vx.tex_v = 2'd1; end
        1: begin sr = -1; su = 1; vx.tex_u = 2'd0; vx.tex_v = 2'd0; end
        2: begin sr = 1; su = 1; vx.tex_u = 2'd2; vx.tex_v = 2'd0; end
        3: begin sr = 1; su = -1; vx.tex_u = 2'd2; vx.tex_v = 2'd2; end
        4: begin sr = -1; su = -1; vx.tex_u = 2'd0; vx.tex_v = 2'd2; end
        default: begin sr = -1; su = 1; vx.tex_u = 2'd0; vx.tex_v = 2'd0; end
      endcase
      if (!sh_tex) begin
        vx.tex_u = 2'd0;
        vx.tex_v = 2'd0;
      end
      v = clamp_pos(ctr[0] + sr * rv[0] + su * uv[0]);
      vx.vert_x = v[19:0];
      v = clamp_pos(ctr[1] + sr * rv[1] + su * uv[1]);
      vx.vert_y = v[19:0];
      v = clamp_pos(ctr[2] + sr * rv[2] + su * uv[2]);
      vx.vert_z = v[19:0];
      vx.vert_color = (k == 0) ? c0 : c1;
      vx.fan_index = 3'(k);
      vx.last_vertex = (k == 5);
      vertex_q.push_back(vx);
    end
  endtask

  // predictor runs on every accepted input transaction
  always @(posedge clk) begin
    if (rst_n && in_valid && !in_stall) begin
      build_fan(in_data);
      n_accepted <= n_accepted + 1;
    end
  end

  // handshake state at the last rising edge, so the driver sees acceptance
  always @(posedge clk) in_taken <= rst_n && in_valid && !in_stall;

  // driver
  always @(negedge clk) begin
    if (rst_n) begin
      if (!in_valid || in_taken) begin
        if (in_gap > 0) begin
          in_valid <= 1'b0;
          in_gap <= in_gap - 1;
        end else if (particle_q.size() > 0) begin
          in_data <= particle_q.pop_front();
          in_valid <= 1'b1;
          in_gap <= $urandom_range(0, 9);
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // receiver stall
  always @(negedge clk) begin
    if (hold_out) begin
      out_stall <= 1'b1;
      hold_len <= hold_len + 1;
    end else if (out_gap > 0) begin
      out_stall <= 1'b1;
      out_gap <= out_gap - 1;
    end else begin
      out_stall <= 1'b0;
      if (out_valid) out_gap <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 9);
    end
  end

  // monitor
  always @(posedge clk) begin
    vertex_t e;
    if (rst_n && out_valid && !out_stall) begin
      n_vertices <= n_vertices + 1;
      if (vertex_q.size() == 0) begin
        $error("vertex with nothing expected: %p", out_data);
        errors++;
      end else begin
        e = vertex_q.pop_front();
        if (out_data.vert_x !== e.vert_x)
          begin $error("vert_x exp %0d got %0d", e.vert_x, out_data.vert_x); errors++; end
        if (out_data.vert_y !== e.vert_y)
          begin $error("vert_y exp %0d got %0d", e.vert_y, out_data.vert_y); errors++; end
        if (out_data.vert_z !== e.vert_z)
          begin $error("vert_z exp %0d got %0d", e.vert_z, out_data.vert_z); errors++; end
        if (out_data.vert_color !== e.vert_color)
          begin $error("vert_color exp %h got %h", e.vert_color, out_data.vert_color); errors++; end
        if (out_data.tex_u !== e.tex_u)
          begin $error("tex_u exp %0d got %0d", e.tex_u, out_data.tex_u); errors++; end
        if (out_data.tex_v !== e.tex_v)
          begin $error("tex_v exp %0d got %0d", e.tex_v, out_data.tex_v); errors++; end
        if (out_data.fan_index !== e.fan_index)
          begin $error("fan_index exp %0d got %0d", e.fan_index, out_data.fan_index); errors++; end
        if (out_data.last_vertex !== e.last_vertex)
          begin $error("last_vertex exp %0d got %0d", e.last_vertex, out_data.last_vertex); errors++; end
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) idle_cnt <= 0;
    else idle_cnt <= idle_cnt + 1;
    if (idle_cnt >= STALL_LIMIT) begin
      $display("watchdog: no transaction for %0d cycles", idle_cnt);
      $display("Regression FAIL");
      $finish;
    end
  end

  task automatic write_reg(input cfg_idx_e idx, input logic [63:0] val);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_idx <= idx;
    cfg_data <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
    case (idx)
      CFG_START_COLORS:   sh_start = val;
      CFG_MID_COLORS:     sh_mid = val;
      CFG_END_COLORS:     sh_end = val;
      CFG_MID_POINT:      sh_midpt = val[16:0];
      CFG_SCREEN_RIGHT:   sh_right = val[47:0];
      CFG_SCREEN_UP:      sh_up = val[47:0];
      CFG_EMITTER_ORIGIN: sh_origin = val[59:0];
      default:            sh_tex = val[0];
    endcase
  endtask

  task automatic drain;
    while (particle_q.size() > 0 || in_valid || vertex_q.size() > 0) @(posedge clk);
    repeat (PIPE_LAT + 10) @(posedge clk);
  endtask

  function automatic particle_t rand_particle(bit extreme);
    particle_t p;
    p.age = 16'($urandom);
    p.lifetime = 16'($urandom);
    p.start_half_width = 16'($urandom);
    p.end_half_width = 16'($urandom);
    p.start_half_height = 16'($urandom);
    p.end_half_height = 16'($urandom);
    p.pos_x = 20'($urandom);
    p.pos_y = 20'($urandom);
    p.pos_z = 20'($urandom);
    if (extreme) begin
      if ($urandom_range(0, 1)) p.pos_x = $urandom_range(0, 1) ? 20'h7FFFF : 20'h80000;
      if ($urandom_range(0, 1)) p.pos_y = $urandom_range(0, 1) ? 20'h7FFFF : 20'h80000;
      if ($urandom_range(0, 1)) p.pos_z = $urandom_range(0, 1) ? 20'h7FFFF : 20'h80000;
    end else begin
      p.pos_x = $signed(20'($urandom_range(0, 8191))) - 20'sd4096;
      p.pos_y = $signed(20'($urandom_range(0, 8191))) - 20'sd4096;
      p.pos_z = $signed(20'($urandom_range(0, 8191))) - 20'sd4096;
    end
    case ($urandom_range(0, 5))
      0: p.lifetime = 0;
      1: p.age = 16'(p.lifetime + $urandom_range(0, 50));
      2: p.age = 16'($urandom_range(0, 1));
      default: if (p.age > p.lifetime) p.age = 16'($urandom_range(0, p.lifetime));
    endcase
    return p;
  endfunction

  task automatic random_config(input int mode);
    logic [63:0] v;
    for (int i = 0; i < 8; i++) begin
      v = {$urandom, $urandom};
      if (mode == 1) v = '1;
      if (mode == 2) v = '0;
      write_reg(cfg_idx_e'(i), v);
    end
  endtask

  initial begin
    particle_t p;
    errors = 0;
    n_accepted = 0;
    n_vertices = 0;
    idle_cnt = 0;
    hold_out = 1'b0;
    hold_len = 0;
    in_gap = 0;
    out_gap = 0;
    in_taken = 1'b0;
    in_valid = 1'b0;
    in_data = '0;
    out_stall = 1'b0;
    cfg_we = 1'b0;
    cfg_idx = CFG_START_COLORS;
    cfg_data = '0;
    sh_start = COLOR_RESET;
    sh_mid = COLOR_RESET;
    sh_end = COLOR_RESET;
    sh_midpt = '0;
    sh_right = '0;
    sh_up = '0;
    sh_origin = '0;
    sh_tex = 1'b0;
    rst_n = 1'b0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // directed: reset configuration, then textured camera with mid color
    p = '0;
    particle_q.push_back(p);
    drain();
    write_reg(CFG_START_COLORS, 64'hFF00_80FF_0010_20FF);
    write_reg(CFG_MID_COLORS, 64'h00FF_4080_8080_8080);
    write_reg(CFG_END_COLORS, 64'h0000_FF00_FFFF_0000);
    write_reg(CFG_MID_POINT, 64'h1_8000);
    write_reg(CFG_SCREEN_RIGHT, 64'h4000_0000_0000);
    write_reg(CFG_SCREEN_UP, 64'h0000_4000_0000);
    write_reg(CFG_EMITTER_ORIGIN, 64'h00100_FFF00_00000);
    write_reg(CFG_TEXTURED, 64'd1);
    p = '0; p.lifetime = 0; p.end_half_width = 16'hFFFF; p.end_half_height = 16'hFFFF;
    particle_q.push_back(p);
    p = '0; p.age = 16'hFFFF; p.lifetime = 16'd10; p.start_half_width = 16'hFFFF;
    particle_q.push_back(p);
    p = '0; p.age = 16'd1; p.lifetime = 16'd4; p.start_half_width = 16'h0100;
    p.end_half_width = 16'h0800; p.start_half_height = 16'h0800; p.pos_x = 20'sh7FFFF;
    particle_q.push_back(p);
    p = '0; p.age = 16'd3; p.lifetime = 16'd4; p.pos_y = 20'sh80000;
    p.start_half_width = 16'hFFFF; p.end_half_height = 16'hFFFF;
    particle_q.push_back(p);
    p = '0; p.age = 16'hFFFE; p.lifetime = 16'hFFFF; p.pos_z = 20'sh7FFFF;
    p.start_half_height = 16'hFFFF; p.end_half_height = 16'hFFFF;
    particle_q.push_back(p);
    p = '0; p.age = 16'd2; p.lifetime = 16'd4;
    particle_q.push_back(p);
    drain();
    random_config(1);
    for (int i = 0; i < 6; i++) particle_q.push_back(rand_particle(1));
    drain();
    random_config(2);
    write_reg(CFG_TEXTURED, 64'd0);
    for (int i = 0; i < 6; i++) particle_q.push_back(rand_particle(1));
    drain();

    // random phases, with a long receiver hold in one of them
    for (int ph = 0; ph < 6; ph++) begin
      random_config(0);
      if (ph % 2 == 0) write_reg(CFG_SCREEN_RIGHT, 64'h4000_0000_0000);
      for (int i = 0; i < N_RANDOM / 6; i++) particle_q.push_back(rand_particle(i % 5 == 0));
      if (ph == 2) begin
        hold_out = 1'b1;
        while (hold_len < 300) @(posedge clk);
        hold_out = 1'b0;
      end
      drain();
    end

    $display("Covered %0d particles, %0d vertices, over several register settings",
             n_accepted, n_vertices);
    $display("including zero lifetime, expired age, mid color and saturated positions");
    if (errors == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
